// ===== src/urcb_pkg.sv =====
// urcb_pkg: shared types and codes for the undo/redo character buffer.
// Used by urcb_ctrl, urcb_dp and the top level; depends on nothing.
package urcb_pkg;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;
  localparam int DEPTH_W  = 7;

  localparam int TEXT_DEPTH_DEF    = 256;
  localparam int HISTORY_DEPTH_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TYPE   = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_UNDO   = 2'd2,
    FUNC_REDO   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic REC_INSERT = 1'b0;
  localparam logic REC_DELETE = 1'b1;

  // history record: kind bit plus the character
  typedef struct packed {
    logic              del;
    logic [CHAR_W-1:0] ch;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    text_len;
    logic [CHAR_W-1:0]   last_char;
    logic [DEPTH_W-1:0]  undo_depth;
    logic [DEPTH_W-1:0]  redo_depth;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    fin;
    logic    text_push;
    logic    text_pop;
    logic    undo_push;
    logic    undo_pop;
    logic    redo_push;
    logic    redo_pop;
    logic    redo_clear;
    status_t status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  text_empty;
    logic  text_full;
    logic  undo_empty;
    logic  redo_empty;
    logic  undo_del;
    logic  redo_del;
  } dp_flags_t;

endpackage

// ===== src/urcb_ram.sv =====
// urcb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module urcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/urcb_ctrl.sv =====
// urcb_ctrl: request sequencer and command decision for the undo/redo buffer.
// Depends on urcb_pkg.
module urcb_ctrl import urcb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_flags_t flags,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // decision on the stack tops read during the accept cycle
  always_comb begin
    cmd        = '0;
    cmd.status = ST_DONE;
    cmd.load   = (state == S_IDLE) && start;
    cmd.exec   = (state == S_EXEC);
    cmd.fin    = (state == S_FIN);
    if (state == S_EXEC) begin
      unique case (flags.func)
        FUNC_TYPE: begin
          if (flags.text_full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.text_push  = 1'b1;
            cmd.undo_push  = 1'b1;
            cmd.redo_clear = 1'b1;
          end
        end
        FUNC_DELETE: begin
          if (flags.text_empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.text_pop   = 1'b1;
            cmd.undo_push  = 1'b1;
            cmd.redo_clear = 1'b1;
          end
        end
        FUNC_UNDO: begin
          if (flags.undo_empty) begin
            cmd.status = ST_EMPTY;
          end else if (flags.undo_del && flags.text_full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.text_push = flags.undo_del;
            cmd.text_pop  = !flags.undo_del && !flags.text_empty;
            cmd.undo_pop  = 1'b1;
            cmd.redo_push = 1'b1;
          end
        end
        FUNC_REDO: begin
          if (flags.redo_empty) begin
            cmd.status = ST_EMPTY;
          end else if (!flags.redo_del && flags.text_full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.text_push = !flags.redo_del;
            cmd.text_pop  = flags.redo_del && !flags.text_empty;
            cmd.redo_pop  = 1'b1;
            cmd.undo_push = 1'b1;
          end
        end
        default: begin
          cmd.status = ST_DONE;
        end
      endcase
    end
  end

endmodule

// ===== src/urcb_dp.sv =====
// urcb_dp: text stack, undo ring, redo stack and result register.
// Depends on urcb_pkg and urcb_ram.
module urcb_dp import urcb_pkg::*; #(
  parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  ctrl_cmd_t cmd,
  output dp_flags_t flags,
  output rsp_t      result
);

  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int TCW = $clog2(TEXT_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  logic [TCW-1:0] text_count;
  logic [HAW-1:0] undo_top;
  logic [HCW-1:0] undo_count;
  logic [HCW-1:0] redo_count;

  func_t             func_q;
  logic [CHAR_W-1:0] ch_q;
  status_t           status_q;
  logic              pop_q;
  logic [CHAR_W-1:0] last_q;

  logic [CHAR_W-1:0] text_rd;
  rec_t              undo_rd;
  rec_t              redo_rd;
  rec_t              rec;

  logic [TCW-1:0] tc_m1;
  logic [TCW-1:0] tc_m2;
  logic [TAW-1:0] text_raddr;
  logic [HAW-1:0] undo_top_m1;
  logic [HAW-1:0] undo_top_p1;
  logic [HCW-1:0] rc_m1;
  logic           redo_we;
  logic [CHAR_W-1:0] last_char_v;

  assign tc_m1       = text_count - TCW'(1);
  assign tc_m2       = text_count - TCW'(2);
  assign text_raddr  = cmd.load ? tc_m1[TAW-1:0] : tc_m2[TAW-1:0];
  assign undo_top_m1 = (undo_top == '0) ? HAW'(HISTORY_DEPTH - 1) : undo_top - HAW'(1);
  assign undo_top_p1 = (undo_top == HAW'(HISTORY_DEPTH - 1)) ? '0 : undo_top + HAW'(1);
  assign rc_m1       = redo_count - HCW'(1);
  assign redo_we     = cmd.redo_push && (redo_count < HCW'(HISTORY_DEPTH));

  // record moved or created by this request
  always_comb begin
    unique case (func_q)
      FUNC_TYPE:   rec = '{del: REC_INSERT, ch: ch_q};
      FUNC_DELETE: rec = '{del: REC_DELETE, ch: text_rd};
      FUNC_UNDO:   rec = undo_rd;
      FUNC_REDO:   rec = redo_rd;
      default:     rec = undo_rd;
    endcase
  end

  assign flags.func       = func_q;
  assign flags.text_empty = (text_count == '0);
  assign flags.text_full  = (text_count == TCW'(TEXT_DEPTH));
  assign flags.undo_empty = (undo_count == '0);
  assign flags.redo_empty = (redo_count == '0);
  assign flags.undo_del   = undo_rd.del;
  assign flags.redo_del   = redo_rd.del;

  urcb_ram #(.WIDTH(CHAR_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (cmd.text_push),
    .waddr (text_count[TAW-1:0]),
    .wdata (rec.ch),
    .raddr (text_raddr),
    .rdata (text_rd)
  );

  urcb_ram #(.WIDTH(REC_W), .DEPTH(HISTORY_DEPTH)) u_undo_ram (
    .clk   (clk),
    .we    (cmd.undo_push),
    .waddr (undo_top),
    .wdata (rec),
    .raddr (undo_top_m1),
    .rdata (undo_rd)
  );

  urcb_ram #(.WIDTH(REC_W), .DEPTH(HISTORY_DEPTH)) u_redo_ram (
    .clk   (clk),
    .we    (redo_we),
    .waddr (redo_count[HAW-1:0]),
    .wdata (rec),
    .raddr (rc_m1[HAW-1:0]),
    .rdata (redo_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      text_count <= '0;
      undo_top   <= '0;
      undo_count <= '0;
      redo_count <= '0;
    end else begin
      if (cmd.text_push) begin
        text_count <= text_count + TCW'(1);
      end else if (cmd.text_pop) begin
        text_count <= tc_m1;
      end

      if (cmd.undo_push) begin
        undo_top <= undo_top_p1;
        if (undo_count < HCW'(HISTORY_DEPTH)) begin
          undo_count <= undo_count + HCW'(1);
        end
      end else if (cmd.undo_pop) begin
        undo_top   <= undo_top_m1;
        undo_count <= undo_count - HCW'(1);
      end

      if (cmd.redo_clear) begin
        redo_count <= '0;
      end else if (redo_we) begin
        redo_count <= redo_count + HCW'(1);
      end else if (cmd.redo_pop) begin
        redo_count <= rc_m1;
      end
    end
  end

  // new last character: pushed char, or the entry below a pop read during exec
  assign last_char_v = (text_count == '0) ? '0 : (pop_q ? text_rd : last_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_t'(req.func);
      ch_q   <= req.ch;
    end
    if (cmd.exec) begin
      status_q <= cmd.status;
      pop_q    <= cmd.text_pop;
      if (cmd.text_push) begin
        last_q <= rec.ch;
      end
    end
    if (cmd.fin) begin
      last_q            <= last_char_v;
      result.status     <= status_q;
      result.text_len   <= LEN_W'(text_count);
      result.last_char  <= last_char_v;
      result.undo_depth <= DEPTH_W'(undo_count);
      result.redo_depth <= DEPTH_W'(redo_count);
    end
  end

  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(undo_count) + int'(redo_count)) <= HISTORY_DEPTH)
    else $error("undo plus redo depth exceeds history size");

  a_text_bound: assert property (@(posedge clk) disable iff (rst)
    int'(text_count) <= TEXT_DEPTH)
    else $error("text count beyond text depth");

  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.text_push && cmd.text_pop) && !(cmd.undo_push && cmd.undo_pop))
    else $error("push and pop on the same stack together");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && cmd.status == ST_FULL) |=> $stable(text_count) && $stable(undo_count))
    else $error("refused request changed state");

  a_redo_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.redo_clear |=> (redo_count == '0))
    else $error("redo history not cleared after new edit");

endmodule

// ===== src/undo_redo_char_buffer_unit.sv =====
// undo_redo_char_buffer_unit: top level of the undo/redo character buffer.
// Depends on urcb_pkg, urcb_ctrl, urcb_dp (and urcb_ram below it).
//
// Usage:
//   Request channel: drive req (func, ch) and raise start. A request is
//   taken at a rising edge where start is high and busy is low. func selects
//   type (append ch), delete last, undo or redo.
//   Result channel: done pulses high for exactly one cycle with result valid
//   (status, text length, last character, undo and redo depths). The
//   receiver cannot stall; a result is taken at the edge ending that cycle.
//   Sequence: the accepting edge moves the unit to the exec state, then to
//   fin, then done is raised; no request is taken while busy. The steps are:
//   read of the text, undo and redo stack tops (registered RAM read), the
//   decision and write-back, then the read of the character below a removed
//   one to form the new last character. busy drops together with done, so
//   the next request can be taken in the cycle done is shown.
//   Reset (rst, synchronous, active high): text length, undo ring pointer
//   and both history depths go to zero. The RAMs are not cleared and need
//   no clearing pass; entries are only read after being written.
//   A full undo history overwrites its oldest record; a type onto full text
//   reports status full and changes nothing.
module undo_redo_char_buffer_unit import urcb_pkg::*; #(
  parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t result
);

  ctrl_cmd_t cmd;
  dp_flags_t flags;

  // sequencer: idle -> exec -> fin, decides stack moves from datapath flags
  urcb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // stacks in RAM plus counters and the result register
  urcb_dp #(
    .TEXT_DEPTH    (TEXT_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .flags  (flags),
    .result (result)
  );

endmodule
